// ===== rtl/i2cwrs_pkg.sv =====
`timescale 1ns / 1ps

package i2cwrs_pkg;

  // Default depth of the write byte buffer.
  localparam int unsigned WRITE_DEPTH_DEF = 32;
  // Depth of the queues between the front, the sequencer and the result port.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Input operation codes.
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  // Controller status codes, after masking.
  localparam logic [7:0] STATUS_MASK  = 8'hF8;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RESTART   = 8'h10;
  localparam logic [7:0] ST_WADDR_ACK = 8'h18;
  localparam logic [7:0] ST_WADDR_NAK = 8'h20;
  localparam logic [7:0] ST_WDATA_ACK = 8'h28;
  localparam logic [7:0] ST_WDATA_NAK = 8'h30;
  localparam logic [7:0] ST_RADDR_ACK = 8'h40;
  localparam logic [7:0] ST_RADDR_NAK = 8'h48;
  localparam logic [7:0] ST_RDATA_ACK = 8'h50;
  localparam logic [7:0] ST_RDATA_NAK = 8'h58;

  typedef enum logic [1:0] {
    KIND_PUSH,
    KIND_START,
    KIND_EVENT
  } kind_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_SEND,
    CMD_RACK,
    CMD_RNACK,
    CMD_STOP
  } cmd_e;

  typedef enum logic [1:0] {
    OUT_OK,
    OUT_NAK,
    OUT_ERR
  } outcome_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [7:0] slave_addr;
    logic [7:0] read_count;
    logic [7:0] status;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    cmd_e       bus_command;
    logic [7:0] tx_byte;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic       done_res;
    outcome_e   outcome;
    logic [7:0] fail_status;
  } result_t;

endpackage

// ===== rtl/i2cwrs_fifo.sv =====
`timescale 1ns / 1ps

module i2cwrs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == DEPTH_C);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_valid_i && !full_o;
  assign do_rd     = rd_ready_i && !empty_o;
  assign rd_data_o = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      store_q[wr_ptr_q] <= wr_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_C)
    else $error("queue count beyond depth");

  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not follow a lone write");
`endif

endmodule

// ===== rtl/i2cwrs_front.sv =====
`timescale 1ns / 1ps

module i2cwrs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         op_i,
  input  logic [7:0]         data_byte_i,
  input  logic [7:0]         slave_addr_i,
  input  logic [7:0]         read_count_i,
  input  logic [7:0]         bus_status_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               item_pop_i,
  output i2cwrs_pkg::item_t  item_o,
  output logic               item_empty_o
);

  import i2cwrs_pkg::*;

  item_t item;
  logic  keep;

  // Unknown operation codes are dropped here and never reach the sequencer.
  always_comb begin
    item.kind        = KIND_PUSH;
    item.data_byte   = data_byte_i;
    item.slave_addr  = slave_addr_i;
    item.read_count  = read_count_i;
    item.status      = bus_status_i & STATUS_MASK;
    item.rx_byte     = rx_byte_i;
    keep             = 1'b1;
    case (op_i)
      OP_PUSH:  item.kind = KIND_PUSH;
      OP_START: item.kind = KIND_START;
      OP_EVENT: item.kind = KIND_EVENT;
      default:  keep = 1'b0;
    endcase
  end

  i2cwrs_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push && keep),
    .wr_data_i  (item),
    .full_o     (full),
    .rd_ready_i (item_pop_i),
    .rd_data_o  (item_o),
    .empty_o    (item_empty_o)
  );

endmodule

// ===== rtl/i2cwrs_back.sv =====
`timescale 1ns / 1ps

module i2cwrs_back #(
  parameter int unsigned WRITE_DEPTH = i2cwrs_pkg::WRITE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_empty_i,
  input  i2cwrs_pkg::item_t   item_i,
  output logic                item_pop_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output i2cwrs_pkg::result_t res_o
);

  import i2cwrs_pkg::*;

  localparam int unsigned AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(WRITE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(WRITE_DEPTH);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_W_START,
    PH_W_ADDR,
    PH_W_DATA,
    PH_R_START,
    PH_R_ADDR,
    PH_R_ACK,
    PH_R_NACK
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [7:0]    reads_q, reads_d;
  logic [7:0]    addr_q, addr_d;
  logic          wrote_q, wrote_d;

  logic [7:0]    wbuf_q [WRITE_DEPTH];
  logic [7:0]    rd_byte_q;
  logic          wbuf_we;

  logic          take;
  logic          res_valid;
  logic          fin;
  logic          bad;
  logic [7:0]    reads_dec;
  logic [7:0]    reads_use;
  logic [7:0]    st;
  result_t       res;

  assign take       = !item_empty_i && !res_full_i;
  assign item_pop_o = take;
  assign res_push_o = take && res_valid;
  assign res_o      = res;
  assign st         = item_i.status;
  assign reads_dec  = (reads_q == '0) ? '0 : reads_q - 1'b1;
  // A data byte with ACK counts one read off before choosing ACK or NACK for the next.
  assign reads_use  = (phase_q == PH_R_ACK) ? reads_dec : reads_q;

  always_comb begin
    phase_d   = phase_q;
    fill_d    = fill_q;
    pos_d     = pos_q;
    reads_d   = reads_q;
    addr_d    = addr_q;
    wrote_d   = wrote_q;
    wbuf_we   = 1'b0;
    res       = '0;
    res_valid = 1'b0;
    fin       = 1'b0;
    bad       = 1'b0;
    if (take) begin
      case (item_i.kind)
        KIND_PUSH: begin
          if (phase_q == PH_IDLE && fill_q < DEPTH_C) begin
            wbuf_we = 1'b1;
            fill_d  = fill_q + 1'b1;
          end
        end
        KIND_START: begin
          if (phase_q == PH_IDLE) begin
            addr_d    = item_i.slave_addr;
            reads_d   = item_i.read_count;
            pos_d     = '0;
            res_valid = 1'b1;
            res.bus_command = CMD_START;
            if (fill_q != '0) begin
              wrote_d = 1'b1;
              phase_d = PH_W_START;
            end else if (item_i.read_count != '0) begin
              wrote_d = 1'b0;
              phase_d = PH_R_START;
            end else begin
              wrote_d = 1'b0;
              res.bus_command = CMD_NONE;
              fin = 1'b1;
            end
          end
        end
        KIND_EVENT: begin
          if (phase_q != PH_IDLE) begin
            res_valid = 1'b1;
            case (phase_q)
              PH_W_START: begin
                if (st == ST_START) begin
                  phase_d         = PH_W_ADDR;
                  res.bus_command = CMD_SEND;
                  res.tx_byte     = {addr_q[7:1], 1'b0};
                end else begin
                  bad = 1'b1;
                end
              end
              PH_W_ADDR: begin
                if (st == ST_WADDR_ACK) begin
                  phase_d         = PH_W_DATA;
                  pos_d           = pos_q + 1'b1;
                  res.bus_command = CMD_SEND;
                  res.tx_byte     = rd_byte_q;
                end else if (st == ST_WADDR_NAK) begin
                  fin = 1'b1;
                  res.bus_command = CMD_STOP;
                  res.outcome     = OUT_NAK;
                  res.fail_status = st;
                end else begin
                  bad = 1'b1;
                end
              end
              PH_W_DATA: begin
                if (st == ST_WDATA_ACK) begin
                  if (pos_q < fill_q) begin
                    pos_d           = pos_q + 1'b1;
                    res.bus_command = CMD_SEND;
                    res.tx_byte     = rd_byte_q;
                  end else if (reads_q != '0) begin
                    phase_d         = PH_R_START;
                    res.bus_command = CMD_START;
                  end else begin
                    fin = 1'b1;
                    res.bus_command = CMD_STOP;
                  end
                end else if (st == ST_WDATA_NAK) begin
                  fin = 1'b1;
                  res.bus_command = CMD_STOP;
                  res.outcome     = OUT_NAK;
                  res.fail_status = st;
                end else begin
                  bad = 1'b1;
                end
              end
              PH_R_START: begin
                if (st == (wrote_q ? ST_RESTART : ST_START)) begin
                  phase_d         = PH_R_ADDR;
                  res.bus_command = CMD_SEND;
                  res.tx_byte     = {addr_q[7:1], 1'b1};
                end else begin
                  bad = 1'b1;
                end
              end
              PH_R_ADDR, PH_R_ACK: begin
                if ((phase_q == PH_R_ADDR && st == ST_RADDR_ACK) ||
                    (phase_q == PH_R_ACK && st == ST_RDATA_ACK)) begin
                  reads_d = reads_use;
                  if (phase_q == PH_R_ACK) begin
                    res.rx_data  = item_i.rx_byte;
                    res.rx_valid = 1'b1;
                  end
                  if (reads_use > 8'd1) begin
                    phase_d         = PH_R_ACK;
                    res.bus_command = CMD_RACK;
                  end else begin
                    phase_d         = PH_R_NACK;
                    res.bus_command = CMD_RNACK;
                  end
                end else if (phase_q == PH_R_ADDR && st == ST_RADDR_NAK) begin
                  fin = 1'b1;
                  res.bus_command = CMD_STOP;
                  res.outcome     = OUT_NAK;
                  res.fail_status = st;
                end else begin
                  bad = 1'b1;
                end
              end
              PH_R_NACK: begin
                if (st == ST_RDATA_NAK) begin
                  fin = 1'b1;
                  res.bus_command = CMD_STOP;
                  res.rx_data     = item_i.rx_byte;
                  res.rx_valid    = 1'b1;
                end else begin
                  bad = 1'b1;
                end
              end
              default: bad = 1'b1;
            endcase
            // Any status the current phase does not expect aborts without a stop.
            if (bad) begin
              fin = 1'b1;
              res = '0;
              res.bus_command = CMD_NONE;
              res.outcome     = OUT_ERR;
              res.fail_status = st;
            end
          end
        end
        default: ;
      endcase
      if (fin) begin
        phase_d      = PH_IDLE;
        fill_d       = '0;
        pos_d        = '0;
        reads_d      = '0;
        res.done_res = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      fill_q  <= '0;
      pos_q   <= '0;
      reads_q <= '0;
      addr_q  <= '0;
      wrote_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
      pos_q   <= pos_d;
      reads_q <= reads_d;
      addr_q  <= addr_d;
      wrote_q <= wrote_d;
    end
  end

  // The read port follows the next send position, so the byte is ready when its event arrives.
  always_ff @(posedge clk_i) begin
    if (wbuf_we) begin
      wbuf_q[fill_q[AW-1:0]] <= item_i.data_byte;
    end
    rd_byte_q <= wbuf_q[pos_d[AW-1:0]];
  end

`ifndef ASSERT_OFF
  a_pos_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= fill_q)
    else $error("send position ran past the buffered bytes");

  a_write_phase_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_W_START || phase_q == PH_W_ADDR || phase_q == PH_W_DATA)
      |-> (fill_q != '0))
    else $error("write phase with an empty buffer");

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res.done_res) |=> (phase_q == PH_IDLE && fill_q == '0))
    else $error("finished transaction did not return to idle");
`endif

endmodule

// ===== rtl/i2c_master_write_read_sequencer.sv =====
`timescale 1ns / 1ps
// Path: an input word is registered in the item queue, and its result word in the result queue before it can be popped.
// Throughput: one input word per cycle; the sequencer handles one word each cycle
// while the result queue has room, set by its single decision stage.
// Reset: rst_ni clears all control state asynchronously; the write buffer is empty
// after reset and its byte storage is not cleared.
module i2c_master_write_read_sequencer #(
  parameter int unsigned WRITE_DEPTH = i2cwrs_pkg::WRITE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] op_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] slave_addr_i,
  input  logic [7:0] read_count_i,
  input  logic [7:0] bus_status_i,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] bus_command_o,
  output logic [7:0] tx_byte_o,
  output logic [7:0] rx_data_o,
  output logic       rx_valid_o,
  output logic       done_res_o,
  output logic [1:0] outcome_o,
  output logic [7:0] fail_status_o
);

  import i2cwrs_pkg::*;

  item_t   item;
  logic    item_empty;
  logic    item_pop;
  logic    res_full;
  logic    res_push;
  result_t res_in;
  result_t res_out;

  i2cwrs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .op_i          (op_i),
    .data_byte_i   (data_byte_i),
    .slave_addr_i  (slave_addr_i),
    .read_count_i  (read_count_i),
    .bus_status_i  (bus_status_i),
    .rx_byte_i     (rx_byte_i),
    .item_pop_i    (item_pop),
    .item_o        (item),
    .item_empty_o  (item_empty)
  );

  i2cwrs_back #(
    .WRITE_DEPTH (WRITE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_empty_i (item_empty),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  i2cwrs_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (res_push),
    .wr_data_i  (res_in),
    .full_o     (res_full),
    .rd_ready_i (pop),
    .rd_data_o  (res_out),
    .empty_o    (empty)
  );

  assign bus_command_o = res_out.bus_command;
  assign tx_byte_o     = res_out.tx_byte;
  assign rx_data_o     = res_out.rx_data;
  assign rx_valid_o    = res_out.rx_valid;
  assign done_res_o    = res_out.done_res;
  assign outcome_o     = res_out.outcome;
  assign fail_status_o = res_out.fail_status;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import i2cwrs_pkg::*;

  localparam int          DEPTH          = WRITE_DEPTH_DEF;
  localparam logic [1:0]  OP_RSVD        = 2'd3;
  localparam int          RAND_WORDS     = 850;
  localparam int          RX_HOLD_CYCLES = 80;
  localparam int          HOLD_AT_WORD   = 300;

  typedef enum logic [3:0] {
    PH_IDLE, PH_W_START, PH_W_ADDR, PH_W_DATA,
    PH_R_START, PH_R_ADDR, PH_R_ACK, PH_R_NACK
  } seq_phase_e;

  typedef struct {
    logic [1:0] op;
    logic [7:0] data_byte;
    logic [7:0] slave_addr;
    logic [7:0] read_count;
    logic [7:0] status;
    logic [7:0] rx_byte;
  } seq_req_t;

  typedef struct {
    seq_req_t rq;
    bit       typed;
    result_t  want;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] op_i = OP_PUSH;
  logic [7:0] data_byte_i = 8'h00;
  logic [7:0] slave_addr_i = 8'h00;
  logic [7:0] read_count_i = 8'h00;
  logic [7:0] bus_status_i = 8'h00;
  logic [7:0] rx_byte_i = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [2:0] bus_command_o;
  logic [7:0] tx_byte_o;
  logic [7:0] rx_data_o;
  logic       rx_valid_o;
  logic       done_res_o;
  logic [1:0] outcome_o;
  logic [7:0] fail_status_o;

  // Predicted sequencer state.
  seq_phase_e seq_phase = PH_IDLE;
  logic [7:0] wbuf [DEPTH];
  int         wfill = 0;
  int         wpos = 0;
  logic [7:0] reads_left = 8'h00;
  logic [7:0] addr_held = 8'h00;
  logic       wrote_first = 1'b0;

  result_t    expected_results [$];
  dir_row_t   dir_rows [$];

  int mismatches = 0;
  int n_in = 0;
  int n_eff = 0;
  int n_out = 0;
  int n_rx_bytes = 0;
  int n_ok = 0;
  int n_nak = 0;
  int n_err = 0;
  int full_cycles = 0;
  int tx_burst = 0;
  int rx_burst = 0;
  int stall_cnt = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  bit run_active = 1'b0;

  i2c_master_write_read_sequencer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .op_i         (op_i),
    .data_byte_i  (data_byte_i),
    .slave_addr_i (slave_addr_i),
    .read_count_i (read_count_i),
    .bus_status_i (bus_status_i),
    .rx_byte_i    (rx_byte_i),
    .empty        (empty),
    .pop          (pop),
    .bus_command_o(bus_command_o),
    .tx_byte_o    (tx_byte_o),
    .rx_data_o    (rx_data_o),
    .rx_valid_o   (rx_valid_o),
    .done_res_o   (done_res_o),
    .outcome_o    (outcome_o),
    .fail_status_o(fail_status_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #12_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic result_t mk_res(input cmd_e cmd, input logic [7:0] tx,
                                     input logic [7:0] rx, input logic rxv,
                                     input logic done, input outcome_e oc,
                                     input logic [7:0] fs);
    result_t r;
    r.bus_command = cmd;
    r.tx_byte     = tx;
    r.rx_data     = rx;
    r.rx_valid    = rxv;
    r.done_res    = done;
    r.outcome     = oc;
    r.fail_status = fs;
    return r;
  endfunction

  // Closes the transaction: buffer emptied, back to idle.
  function automatic result_t wrap_up(input cmd_e cmd, input logic [7:0] rx,
                                      input logic rxv, input outcome_e oc,
                                      input logic [7:0] fs);
    seq_phase  = PH_IDLE;
    wfill      = 0;
    wpos       = 0;
    reads_left = 8'h00;
    return mk_res(cmd, 8'h00, rx, rxv, 1'b1, oc, fs);
  endfunction

  function automatic result_t next_data();
    logic [7:0] b;
    b = wbuf[wpos];
    wpos++;
    seq_phase = PH_W_DATA;
    return mk_res(CMD_SEND, b, 8'h00, 1'b0, 1'b0, OUT_OK, 8'h00);
  endfunction

  // The last byte of a read is taken with NACK, all others with ACK.
  function automatic result_t read_cmd(input logic [7:0] rx, input logic rxv);
    if (reads_left > 8'd1) begin
      seq_phase = PH_R_ACK;
      return mk_res(CMD_RACK, 8'h00, rx, rxv, 1'b0, OUT_OK, 8'h00);
    end
    seq_phase = PH_R_NACK;
    return mk_res(CMD_RNACK, 8'h00, rx, rxv, 1'b0, OUT_OK, 8'h00);
  endfunction

  function automatic bit sequence_step(input seq_req_t rq, output result_t res);
    logic [7:0] st;
    bit         bad;
    st  = rq.status & STATUS_MASK;
    res = '0;
    bad = 1'b1;
    case (rq.op)
      OP_PUSH: begin
        if (seq_phase == PH_IDLE && wfill < DEPTH) begin
          wbuf[wfill] = rq.data_byte;
          wfill++;
        end
        return 1'b0;
      end
      OP_START: begin
        if (seq_phase != PH_IDLE) return 1'b0;
        addr_held  = rq.slave_addr;
        reads_left = rq.read_count;
        wpos       = 0;
        if (wfill > 0) begin
          wrote_first = 1'b1;
          seq_phase   = PH_W_START;
        end else if (reads_left > 8'd0) begin
          wrote_first = 1'b0;
          seq_phase   = PH_R_START;
        end else begin
          wrote_first = 1'b0;
          res = wrap_up(CMD_NONE, 8'h00, 1'b0, OUT_OK, 8'h00);
          return 1'b1;
        end
        res = mk_res(CMD_START, 8'h00, 8'h00, 1'b0, 1'b0, OUT_OK, 8'h00);
        return 1'b1;
      end
      OP_EVENT: begin
        if (seq_phase == PH_IDLE) return 1'b0;
      end
      default: return 1'b0;
    endcase

    bad = 1'b0;
    case (seq_phase)
      PH_W_START: begin
        if (st == ST_START) begin
          seq_phase = PH_W_ADDR;
          res = mk_res(CMD_SEND, addr_held & 8'hFE, 8'h00, 1'b0, 1'b0, OUT_OK, 8'h00);
        end else bad = 1'b1;
      end
      PH_W_ADDR: begin
        if (st == ST_WADDR_ACK) res = next_data();
        else if (st == ST_WADDR_NAK) res = wrap_up(CMD_STOP, 8'h00, 1'b0, OUT_NAK, st);
        else bad = 1'b1;
      end
      PH_W_DATA: begin
        if (st == ST_WDATA_ACK) begin
          if (wpos < wfill) begin
            res = next_data();
          end else if (reads_left > 8'd0) begin
            seq_phase = PH_R_START;
            res = mk_res(CMD_START, 8'h00, 8'h00, 1'b0, 1'b0, OUT_OK, 8'h00);
          end else begin
            res = wrap_up(CMD_STOP, 8'h00, 1'b0, OUT_OK, 8'h00);
          end
        end else if (st == ST_WDATA_NAK) begin
          res = wrap_up(CMD_STOP, 8'h00, 1'b0, OUT_NAK, st);
        end else bad = 1'b1;
      end
      PH_R_START: begin
        if (st == (wrote_first ? ST_RESTART : ST_START)) begin
          seq_phase = PH_R_ADDR;
          res = mk_res(CMD_SEND, addr_held | 8'h01, 8'h00, 1'b0, 1'b0, OUT_OK, 8'h00);
        end else bad = 1'b1;
      end
      PH_R_ADDR: begin
        if (st == ST_RADDR_ACK) res = read_cmd(8'h00, 1'b0);
        else if (st == ST_RADDR_NAK) res = wrap_up(CMD_STOP, 8'h00, 1'b0, OUT_NAK, st);
        else bad = 1'b1;
      end
      PH_R_ACK: begin
        if (st == ST_RDATA_ACK) begin
          if (reads_left > 8'd0) reads_left--;
          res = read_cmd(rq.rx_byte, 1'b1);
        end else bad = 1'b1;
      end
      PH_R_NACK: begin
        if (st == ST_RDATA_NAK) res = wrap_up(CMD_STOP, rq.rx_byte, 1'b1, OUT_OK, 8'h00);
        else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    // Any status the current step does not expect ends the transfer without a stop.
    if (bad) res = wrap_up(CMD_NONE, 8'h00, 1'b0, OUT_ERR, st);
    return 1'b1;
  endfunction

  // Mostly the status the sequencer waits for, sometimes a NAK, rarely anything.
  function automatic logic [7:0] pick_status();
    logic [7:0] good;
    logic [7:0] nak;
    logic [7:0] s;
    int         r;
    nak = 8'h00;
    case (seq_phase)
      PH_W_ADDR: begin
        good = ST_WADDR_ACK;
        nak  = ST_WADDR_NAK;
      end
      PH_W_DATA: begin
        good = ST_WDATA_ACK;
        nak  = ST_WDATA_NAK;
      end
      PH_R_START: good = wrote_first ? ST_RESTART : ST_START;
      PH_R_ADDR: begin
        good = ST_RADDR_ACK;
        nak  = ST_RADDR_NAK;
      end
      PH_R_ACK:  good = ST_RDATA_ACK;
      PH_R_NACK: good = ST_RDATA_NAK;
      default:   good = ST_START;
    endcase
    r = $urandom_range(0, 99);
    if (r < 88) s = good;
    else if (r < 94 && nak != 8'h00) s = nak;
    else s = 8'($urandom_range(0, 255));
    return s | 8'($urandom_range(0, 7));
  endfunction

  function automatic seq_req_t rand_req(input logic [1:0] op);
    seq_req_t rq;
    rq.op          = op;
    rq.data_byte   = 8'($urandom_range(0, 255));
    rq.slave_addr  = 8'($urandom_range(0, 255));
    rq.read_count  = 8'($urandom_range(0, 255));
    rq.status      = 8'($urandom_range(0, 255));
    rq.rx_byte     = 8'($urandom_range(0, 255));
    return rq;
  endfunction

  function automatic int gap_len(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 50);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", what, got, want));
  endtask

  task automatic row(input logic [1:0] op, input logic [7:0] d, input logic [7:0] a,
                     input logic [7:0] c, input logic [7:0] s, input logic [7:0] r,
                     input bit typed = 1'b0, input result_t want = '0);
    dir_row_t dr;
    dr.rq    = '{op, d, a, c, s, r};
    dr.typed = typed;
    dr.want  = want;
    dir_rows.push_back(dr);
  endtask

  task automatic offer(input seq_req_t rq, input bit typed, input result_t want);
    result_t res;
    bit      has;
    bit      eff;
    push          <= 1'b1;
    op_i          <= rq.op;
    data_byte_i   <= rq.data_byte;
    slave_addr_i  <= rq.slave_addr;
    read_count_i  <= rq.read_count;
    bus_status_i  <= rq.status;
    rx_byte_i     <= rq.rx_byte;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    eff = ((rq.op == OP_PUSH || rq.op == OP_START) && seq_phase == PH_IDLE) ||
          (rq.op == OP_EVENT && seq_phase != PH_IDLE);
    has = sequence_step(rq, res);
    if (typed) expected_results.push_back(want);
    else if (has) expected_results.push_back(res);
    n_in++;
    if (eff) n_eff++;
  endtask

  task automatic sender_idle();
    int g;
    g = gap_len(tx_burst);
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Result side: checks each popped word and drives pop with random stalls.
  always @(posedge clk_i) begin
    int      g;
    result_t head;
    if (run_active) begin
      if (push && full) full_cycles++;
      if (pop && !empty) begin
        n_out++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending, command 0x%0h",
                                    bus_command_o));
        end else begin
          head = expected_results.pop_front();
          check_field("bus_command", bus_command_o, head.bus_command);
          check_field("tx_byte", tx_byte_o, head.tx_byte);
          check_field("rx_data", rx_data_o, head.rx_data);
          check_field("rx_valid", rx_valid_o, head.rx_valid);
          check_field("done_res", done_res_o, head.done_res);
          check_field("outcome", outcome_o, head.outcome);
          check_field("fail_status", fail_status_o, head.fail_status);
          if (head.rx_valid) n_rx_bytes++;
          if (head.done_res) begin
            case (head.outcome)
              OUT_OK:  n_ok++;
              OUT_NAK: n_nak++;
              default: n_err++;
            endcase
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        stall_cnt = RX_HOLD_CYCLES;
      end
      if (stall_cnt > 0) begin
        pop <= 1'b0;
        stall_cnt--;
      end else begin
        g = gap_len(rx_burst);
        if (g == 0) begin
          pop <= 1'b1;
        end else begin
          pop <= 1'b0;
          stall_cnt = g - 1;
        end
      end
    end
  end

  initial begin
    seq_req_t rq;
    int       r;
    int       nwr;
    int       rc;

    // Empty transaction, ignored words, then a full write-then-read transfer.
    row(OP_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
        mk_res(CMD_NONE, 8'h00, 8'h00, 1'b0, 1'b1, OUT_OK, 8'h00));
    row(OP_EVENT, 8'h00, 8'h00, 8'h00, ST_START, 8'h00);
    row(OP_RSVD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    row(OP_PUSH, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    row(OP_PUSH, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
    row(OP_START, 8'h00, 8'hFF, 8'h02, 8'h00, 8'h00, 1'b1,
        mk_res(CMD_START, 8'h00, 8'h00, 1'b0, 1'b0, OUT_OK, 8'h00));
    row(OP_PUSH, 8'h55, 8'h00, 8'h00, 8'h00, 8'h00);
    row(OP_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    row(OP_EVENT, 8'h00, 8'h00, 8'h00, ST_START | 8'h07, 8'h00);
    row(OP_EVENT, 8'h00, 8'h00, 8'h00, ST_WADDR_ACK, 8'h00);
    row(OP_EVENT, 8'h00, 8'h00, 8'h00, ST_WDATA_ACK, 8'h00);
    row(OP_EVENT, 8'h00, 8'h00, 8'h00, ST_WDATA_ACK, 8'h00);
    row(OP_EVENT, 8'h00, 8'h00, 8'h00, ST_RESTART, 8'h00);
    row(OP_EVENT, 8'h00, 8'h00, 8'h00, ST_RADDR_ACK, 8'h00);
    row(OP_EVENT, 8'h00, 8'h00, 8'h00, ST_RDATA_ACK, 8'hA5);
    row(OP_EVENT, 8'h00, 8'h00, 8'h00, ST_RDATA_NAK, 8'hFF);
    // Address NAK on the write, with the largest read count pending.
    row(OP_PUSH, 8'h12, 8'h00, 8'h00, 8'h00, 8'h00);
    row(OP_START, 8'h00, 8'h20, 8'hFF, 8'h00, 8'h00);
    row(OP_EVENT, 8'h00, 8'h00, 8'h00, ST_START, 8'h00);
    row(OP_EVENT, 8'h00, 8'h00, 8'h00, ST_WADDR_NAK, 8'h00, 1'b1,
        mk_res(CMD_STOP, 8'h00, 8'h00, 1'b0, 1'b1, OUT_NAK, ST_WADDR_NAK));
    // Read-only transfer hit by a status nobody expects.
    row(OP_START, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00);
    row(OP_EVENT, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b1,
        mk_res(CMD_NONE, 8'h00, 8'h00, 1'b0, 1'b1, OUT_ERR, 8'hF8));
    // Read-only transfer whose address is not acknowledged.
    row(OP_START, 8'h00, 8'h7F, 8'h01, 8'h00, 8'h00);
    row(OP_EVENT, 8'h00, 8'h00, 8'h00, ST_START, 8'h00);
    row(OP_EVENT, 8'h00, 8'h00, 8'h00, ST_RADDR_NAK, 8'h00, 1'b1,
        mk_res(CMD_STOP, 8'h00, 8'h00, 1'b0, 1'b1, OUT_NAK, ST_RADDR_NAK));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_active = 1'b1;

    foreach (dir_rows[i]) begin
      offer(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
      sender_idle();
    end

    while (n_in < RAND_WORDS) begin
      if (n_in >= HOLD_AT_WORD && !hold_req) begin
        // Keep offering back to back while the result side is held off.
        hold_req = 1'b1;
        tx_burst = 2 * RX_HOLD_CYCLES;
      end
      rq = rand_req(OP_EVENT);
      r  = $urandom_range(0, 99);
      if (r < 3) begin
        rq.op = OP_RSVD;
      end else if (r < 6) begin
        if (seq_phase != PH_IDLE) rq.op = (r == 3) ? OP_PUSH : OP_START;
      end else if (seq_phase == PH_IDLE) begin
        r = $urandom_range(0, 99);
        if (r < 70) nwr = $urandom_range(0, 3);
        else if (r < 93) nwr = $urandom_range(4, 8);
        else nwr = $urandom_range(DEPTH - 2, DEPTH + 4);
        for (int k = 0; k < nwr; k++) begin
          offer(rand_req(OP_PUSH), 1'b0, '0);
          sender_idle();
        end
        r = $urandom_range(0, 99);
        if (r < 90) rc = $urandom_range(0, 4);
        else if (r < 99) rc = $urandom_range(5, 20);
        else rc = $urandom_range(0, 255);
        rq.op         = OP_START;
        rq.read_count = 8'(rc);
      end else begin
        rq.status = pick_status();
      end
      offer(rq, 1'b0, '0);
      sender_idle();
    end
    push <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("Sent %0d words, %0d of them acted on; input stalled %0d cycles.",
             n_in, n_eff, full_cycles);
    $display("Checked %0d results with %0d read bytes; transfers: %0d ok, %0d NAK, %0d error.",
             n_out, n_rx_bytes, n_ok, n_nak, n_err);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/i2cwrs_pkg.sv
rtl/i2cwrs_fifo.sv
rtl/i2cwrs_front.sv
rtl/i2cwrs_back.sv
rtl/i2c_master_write_read_sequencer.sv
sim/tb_top.sv
